// ===== rtl/ttss_pkg.sv =====
package ttss_pkg;

  // Fixed field widths of the request and result words
  localparam int IN_W   = 16;
  localparam int COIL_W = 8;
  localparam int OUT_W  = 16;

  // Default table depth and step count after reset
  localparam int MAX_RULES_DEF = 8;
  localparam int STEP_W        = 4;
  localparam logic [STEP_W-1:0] STEP_RESET = 4'd8;

  // Request kind carried on tuser
  localparam logic FUNC_SCAN  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // One rule of the truth table
  typedef struct packed {
    logic              all_match;
    logic [IN_W-1:0]   in_pat;
    logic [IN_W-1:0]   in_mask;
    logic [COIL_W-1:0] coil_pat;
    logic [COIL_W-1:0] coil_mask;
    logic [COIL_W-1:0] coil_next;
    logic [OUT_W-1:0]  out_keep;
    logic [OUT_W-1:0]  out_set;
  } rule_t;

  // Rule contents after reset: everything masked, ONE mode, output untouched
  localparam rule_t RULE_RESET = '{
    all_match: 1'b0,
    in_pat:    '0,
    in_mask:   '1,
    coil_pat:  '0,
    coil_mask: '1,
    coil_next: '0,
    out_keep:  '1,
    out_set:   '0
  };

  // Scan state handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [IN_W-1:0]   word;
    logic [COIL_W-1:0] coil;
    logic [OUT_W-1:0]  out;
  } stage_t;

endpackage

// ===== rtl/ttss_cell.sv =====
module ttss_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  ttss_pkg::rule_t  wr_rule,
  input  logic             enable,
  input  ttss_pkg::stage_t prev,
  output ttss_pkg::stage_t nxt
);

  ttss_pkg::rule_t rule;

  logic [ttss_pkg::IN_W-1:0]   in_m;
  logic [ttss_pkg::COIL_W-1:0] co_m;
  logic                        hit_all;
  logic                        hit_one;
  logic                        hit;
  logic [ttss_pkg::COIL_W-1:0] coil_next;
  logic [ttss_pkg::OUT_W-1:0]  out_next;

  logic                        st_valid;
  logic [ttss_pkg::IN_W-1:0]   st_word;
  logic [ttss_pkg::COIL_W-1:0] st_coil;
  logic [ttss_pkg::OUT_W-1:0]  st_out;

  // Hold this cell's rule, load it on a write request
  always_ff @(posedge clk) begin
    if (rst) begin
      rule <= ttss_pkg::RULE_RESET;
    end else if (wr_en) begin
      rule <= wr_rule;
    end
  end

  // Test the rule against the state left by the previous cell
  always_comb begin
    in_m    = prev.word & ~rule.in_mask;
    co_m    = prev.coil & ~rule.coil_mask;
    hit_all = (in_m == rule.in_pat) && (co_m == rule.coil_pat);
    hit_one = (|in_m) || (|co_m);
    hit     = enable && (rule.all_match ? hit_all : hit_one);
    coil_next = hit ? rule.coil_next : prev.coil;
    out_next  = hit ? ((prev.out & rule.out_keep) | rule.out_set) : prev.out;
  end

  // Advance the scan token
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= prev.valid;
    end
  end

  // Hand the updated state to the next cell
  always_ff @(posedge clk) begin
    st_word <= prev.word;
    st_coil <= coil_next;
    st_out  <= out_next;
  end

  assign nxt.valid = st_valid;
  assign nxt.word  = st_word;
  assign nxt.coil  = st_coil;
  assign nxt.out   = st_out;

endmodule

// ===== rtl/truth_table_step_sequencer.sv =====
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tuser: func; s_tdata: scan and rule fields
// m        out  m_tvalid/m_tready  m_tdata: output_word, coil_state
// cfg      in   cfg_we             cfg_data: step_count
//
// A scan with auto_run passes through a chain of MAX_RULES cells, one rule per
// cell and cycle. No new request is taken until the result has been loaded into
// the output register, for a rule write or a scan without auto_run as well.
// Reset (rst, synchronous) clears the coil and output words, loads every rule
// with its all-masked ONE-mode value and sets step_count to 8.
// One finished result waits in the output register while the next request is
// accepted; a stalled m side then holds the following result inside the block.
module truth_table_step_sequencer #(
  parameter int MAX_RULES = ttss_pkg::MAX_RULES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [15:0] scan_input, [16] auto_run, [19:17] rule_index, [20] rule_all_match,
  // [36:21] rule_input_pattern, [52:37] rule_input_mask,
  // [60:53] rule_coil_pattern, [68:61] rule_coil_mask, [76:69] rule_coil_next,
  // [92:77] rule_output_keep, [108:93] rule_output_set, [111:109] zero
  input  logic [111:0] s_tdata,
  // [0] func
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [15:0] output_word, [23:16] coil_state
  output logic [23:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_data
);

  logic [ttss_pkg::STEP_W-1:0] step_count;
  logic [ttss_pkg::COIL_W-1:0] coil_reg;
  logic [ttss_pkg::OUT_W-1:0]  out_reg;
  logic                        busy;
  logic                        pend;
  logic [23:0]                 obuf;

  logic                        s_accept;
  logic                        is_write;
  logic                        auto_run;
  logic [2:0]                  rule_index;
  logic [ttss_pkg::IN_W-1:0]   scan_input;
  ttss_pkg::rule_t             wr_rule;
  logic                        out_load;
  logic [MAX_RULES-1:0]        cell_en;
  logic [MAX_RULES-1:0]        cell_wr;
  logic [MAX_RULES-1:0]        cell_valid;
  ttss_pkg::stage_t            link [MAX_RULES+1];

  // Unpack the request
  assign scan_input         = s_tdata[15:0];
  assign auto_run           = s_tdata[16];
  assign rule_index         = s_tdata[19:17];
  assign wr_rule.all_match  = s_tdata[20];
  assign wr_rule.in_pat     = s_tdata[36:21];
  assign wr_rule.in_mask    = s_tdata[52:37];
  assign wr_rule.coil_pat   = s_tdata[60:53];
  assign wr_rule.coil_mask  = s_tdata[68:61];
  assign wr_rule.coil_next  = s_tdata[76:69];
  assign wr_rule.out_keep   = s_tdata[92:77];
  assign wr_rule.out_set    = s_tdata[108:93];
  assign is_write           = (s_tuser[0] == ttss_pkg::FUNC_WRITE);

  assign s_tready = !busy && !pend;
  assign s_accept = s_tvalid && s_tready;
  assign out_load = pend && (!m_tvalid || m_tready);

  // Hold the step count register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= ttss_pkg::STEP_RESET;
    end else if (cfg_we) begin
      step_count <= cfg_data;
    end
  end

  // Feed a running scan into the head of the chain
  assign link[0].valid = s_accept && !is_write && auto_run;
  assign link[0].word  = scan_input;
  assign link[0].coil  = coil_reg;
  assign link[0].out   = out_reg;

  // Build the chain of rule cells
  for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
    assign cell_en[g]    = int'(step_count) > g;
    assign cell_wr[g]    = s_accept && is_write && (int'(rule_index) == g);
    assign cell_valid[g] = link[g+1].valid;
    ttss_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (cell_wr[g]),
      .wr_rule (wr_rule),
      .enable  (cell_en[g]),
      .prev    (link[g]),
      .nxt     (link[g+1])
    );
  end

  // Track the scan in flight and the result owed to the output
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pend     <= 1'b0;
      coil_reg <= '0;
      out_reg  <= '0;
    end else begin
      if (s_accept) begin
        if (link[0].valid) begin
          busy <= 1'b1;
        end else begin
          pend <= 1'b1;
        end
      end else if (link[MAX_RULES].valid) begin
        busy     <= 1'b0;
        pend     <= 1'b1;
        coil_reg <= link[MAX_RULES].coil;
        out_reg  <= link[MAX_RULES].out;
      end else if (out_load) begin
        pend <= 1'b0;
      end
    end
  end

  // Hold the result until the m side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      obuf <= {coil_reg, out_reg};
    end
  end

  assign m_tdata = obuf;

  a_busy_pend: assert property (@(posedge clk) disable iff (rst) !(busy && pend))
    else $error("scan in flight while a result is owed");
  a_exit_busy: assert property (@(posedge clk) disable iff (rst)
    link[MAX_RULES].valid |-> busy)
    else $error("chain output without a scan in flight");
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(cell_valid))
    else $error("more than one scan in the chain");
  a_quick_pend: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !link[0].valid) |=> pend)
    else $error("write or idle scan left no result");
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    link[0].valid |=> busy)
    else $error("running scan not marked busy");

endmodule

// ===== tb/tb_truth_table_step_sequencer.sv =====
`timescale 1ns / 1ps

module tb_truth_table_step_sequencer;

  localparam int N_RULES = ttss_pkg::MAX_RULES_DEF;
  // Step counts for the random phases, lowest nibble first
  localparam logic [31:0] STEP_PLAN = {4'd9, 4'd6, 4'd11, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8};

  typedef struct packed {
    logic                        func;
    logic [ttss_pkg::IN_W-1:0]   scan_word;
    logic                        auto_run;
    logic [2:0]                  slot;
    ttss_pkg::rule_t             rule;
  } request_t;

  typedef struct packed {
    logic [ttss_pkg::OUT_W-1:0]  out_word;
    logic [ttss_pkg::COIL_W-1:0] coil;
  } result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // [15:0] scan_input, [16] auto_run, [19:17] rule_index, [20] rule_all_match,
  // [36:21] rule_input_pattern, [52:37] rule_input_mask,
  // [60:53] rule_coil_pattern, [68:61] rule_coil_mask, [76:69] rule_coil_next,
  // [92:77] rule_output_keep, [108:93] rule_output_set, [111:109] zero
  logic [111:0] s_tdata;
  // [0] func
  logic [0:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  // [15:0] output_word, [23:16] coil_state
  logic [23:0]  m_tdata;
  logic         cfg_we;
  logic [3:0]   cfg_data;

  // Shadow copy of the sequencer state
  logic [3:0]                  steps_cfg;
  logic [ttss_pkg::COIL_W-1:0] coil_reg;
  logic [ttss_pkg::OUT_W-1:0]  out_reg;
  ttss_pkg::rule_t             rule_tbl [N_RULES];

  result_t expected_outputs [$];
  int      mismatches;
  int      n_checked;
  int      n_scans;
  int      n_writes;
  bit      idle_on;
  int      sink_hold;

  truth_table_step_sequencer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic note_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch on %s at %0t ns: got %0h, want %0h", what, $realtime, got, want);
  endtask

  // Advance the shadow state by one request and queue the result it yields
  function automatic void apply_request(request_t r);
    logic [ttss_pkg::IN_W-1:0]   in_bits;
    logic [ttss_pkg::COIL_W-1:0] co_bits;
    logic                        hit;
    int                          n;
    result_t                     res;
    if (r.func == ttss_pkg::FUNC_WRITE) begin
      n_writes++;
      if (r.slot < N_RULES) rule_tbl[r.slot] = r.rule;
    end else begin
      n_scans++;
      if (r.auto_run) begin
        n = (steps_cfg > N_RULES) ? N_RULES : steps_cfg;
        for (int i = 0; i < n; i++) begin
          in_bits = r.scan_word & ~rule_tbl[i].in_mask;
          co_bits = coil_reg & ~rule_tbl[i].coil_mask;
          if (rule_tbl[i].all_match)
            hit = (in_bits == rule_tbl[i].in_pat) && (co_bits == rule_tbl[i].coil_pat);
          else
            hit = (in_bits != '0) || (co_bits != '0);
          if (hit) begin
            coil_reg = rule_tbl[i].coil_next;
            out_reg  = (out_reg & rule_tbl[i].out_keep) | rule_tbl[i].out_set;
          end
        end
      end
    end
    res.out_word = out_reg;
    res.coil     = coil_reg;
    expected_outputs.insert(expected_outputs.size(), res);
  endfunction

  function automatic request_t scan_req(logic [ttss_pkg::IN_W-1:0] word, logic run);
    request_t    r;
    logic [95:0] raw;
    raw         = {$urandom, $urandom, $urandom};
    r           = '0;
    r.func      = ttss_pkg::FUNC_SCAN;
    r.scan_word = word;
    r.auto_run  = run;
    r.rule      = raw[$bits(ttss_pkg::rule_t)-1:0];
    return r;
  endfunction

  function automatic request_t rule_req(logic [2:0] slot, logic all_match,
                                        logic [15:0] in_pat, logic [15:0] in_mask,
                                        logic [7:0] coil_pat, logic [7:0] coil_mask,
                                        logic [7:0] coil_next, logic [15:0] keep,
                                        logic [15:0] set_bits);
    request_t r;
    r                = '0;
    r.func           = ttss_pkg::FUNC_WRITE;
    r.scan_word      = 16'($urandom);
    r.auto_run       = 1'($urandom_range(0, 1));
    r.slot           = slot;
    r.rule.all_match = all_match;
    r.rule.in_pat    = in_pat;
    r.rule.in_mask   = in_mask;
    r.rule.coil_pat  = coil_pat;
    r.rule.coil_mask = coil_mask;
    r.rule.coil_next = coil_next;
    r.rule.out_keep  = keep;
    r.rule.out_set   = set_bits;
    return r;
  endfunction

  // Build a likely-firing rule: the input pattern mostly lies outside its mask and
  // the coil pattern follows the next-coil value of some rule in the table
  function automatic request_t random_rule(logic [2:0] slot);
    logic [15:0] in_mask;
    logic [7:0]  coil_mask;
    logic [15:0] in_pat;
    logic [7:0]  coil_pat;
    case ($urandom_range(0, 3))
      0:       in_mask = 16'($urandom);
      1:       in_mask = '1;
      2:       in_mask = ~(16'h1 << $urandom_range(0, 15));
      default: in_mask = '0;
    endcase
    case ($urandom_range(0, 3))
      0:       coil_mask = 8'($urandom);
      1:       coil_mask = '0;
      default: coil_mask = '1;
    endcase
    in_pat   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom) & ~in_mask;
    coil_pat = rule_tbl[$urandom_range(0, N_RULES - 1)].coil_next & ~coil_mask;
    return rule_req(slot, 1'($urandom_range(0, 1)), in_pat, in_mask, coil_pat, coil_mask,
                    8'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  // Pick an input word that is likely to satisfy one of the stored rules
  function automatic logic [ttss_pkg::IN_W-1:0] scan_word_near();
    int k;
    k = $urandom_range(0, N_RULES - 1);
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return '0;
      2:       return '1;
      default: return (rule_tbl[k].in_pat & ~rule_tbl[k].in_mask) |
                      (16'($urandom) & rule_tbl[k].in_mask);
    endcase
  endfunction

  function automatic request_t random_item();
    request_t     r;
    logic [127:0] raw;
    case ($urandom_range(0, 19))
      0: begin
        raw = {$urandom, $urandom, $urandom, $urandom};
        r   = raw[$bits(request_t)-1:0];
      end
      1, 2, 3:   r = random_rule(3'($urandom_range(0, 7)));
      default:   r = scan_req(scan_word_near(), $urandom_range(0, 9) != 0);
    endcase
    return r;
  endfunction

  // Offer one request, with an optional idle burst first, and hold until taken
  task automatic send_request(request_t r);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.func;
    s_tdata  <= {3'b000, r.rule.out_set, r.rule.out_keep, r.rule.coil_next,
                 r.rule.coil_mask, r.rule.coil_pat, r.rule.in_mask, r.rule.in_pat,
                 r.rule.all_match, r.slot, r.auto_run, r.scan_word};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    apply_request(r);
  endtask

  // Drop valid and hold until every queued result has been seen
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic set_step_count(logic [3:0] value);
    drain_results();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    steps_cfg = value;
  endtask

  // Result side: random stall bursts, plus a long hold when a test asks
  initial begin
    int burst;
    burst    = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        m_tready <= 1'b0;
        sink_hold--;
      end else if (burst > 0) begin
        m_tready <= 1'b0;
        burst--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        burst = $urandom_range(1, 6) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest prediction
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
        if (expected_outputs.size() == 0) begin
          note_mismatch("result with nothing pending", 32'(m_tdata), 0);
        end else begin
          want = expected_outputs.pop_front();
          n_checked++;
          if (m_tdata[15:0] !== want.out_word)
            note_mismatch("output_word", 32'(m_tdata[15:0]), 32'(want.out_word));
          if (m_tdata[23:16] !== want.coil)
            note_mismatch("coil_state", 32'(m_tdata[23:16]), 32'(want.coil));
        end
      end
    end
  end

  // Default table: every rule masked out, so scans change nothing
  task automatic test_reset_state();
    send_request(scan_req(16'h0000, 1'b1));
    send_request(scan_req(16'hFFFF, 1'b1));
    send_request(scan_req(16'hA5A5, 1'b0));
  endtask

  task automatic test_rule_matching();
    // ONE mode on input bits, then a miss and a hit
    send_request(rule_req(3'd0, 1'b0, 16'h0000, 16'h0000, 8'h00, 8'hFF,
                          8'h81, 16'h0000, 16'h00F0));
    send_request(scan_req(16'h0000, 1'b1));
    send_request(scan_req(16'h8000, 1'b1));
    // ONE mode on coil bit 7 only, chained on the coil left by rule 0
    send_request(rule_req(3'd1, 1'b0, 16'h0000, 16'hFFFF, 8'h00, 8'h7F,
                          8'h00, 16'hFFFF, 16'h0F00));
    send_request(scan_req(16'h0000, 1'b1));
    // ALL mode with exact input and coil patterns
    send_request(rule_req(3'd2, 1'b1, 16'h1234, 16'h0000, 8'h00, 8'h00,
                          8'h42, 16'h00FF, 16'hC000));
    send_request(scan_req(16'h1234, 1'b1));
    // ALL mode with a pattern bit under its mask: never fires
    send_request(rule_req(3'd3, 1'b1, 16'h0001, 16'h0001, 8'h00, 8'hFF,
                          8'h3C, 16'h0000, 16'h0000));
    // ALL mode fully masked: always fires, drives outputs to all ones
    send_request(rule_req(3'd7, 1'b1, 16'h0000, 16'hFFFF, 8'h00, 8'hFF,
                          8'hFF, 16'h0000, 16'hFFFF));
    send_request(scan_req(16'hFFFF, 1'b1));
    // Every rule field at its top value
    send_request(rule_req(3'd6, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                          8'hFF, 16'hFFFF, 16'hFFFF));
    // Scan with auto-run clear leaves the state alone
    send_request(scan_req(16'hFFFF, 1'b0));
  endtask

  // Zero, one, partial table and saturated step counts
  task automatic test_step_count();
    send_request(rule_req(3'd5, 1'b1, 16'h0000, 16'hFFFF, 8'h00, 8'hFF,
                          8'h55, 16'h0000, 16'h0005));
    set_step_count(4'd0);
    send_request(scan_req(16'h8001, 1'b1));
    set_step_count(4'd1);
    send_request(scan_req(16'h8001, 1'b1));
    set_step_count(4'd6);
    send_request(scan_req(16'h0000, 1'b1));
    set_step_count(4'd9);
    send_request(scan_req(16'h4000, 1'b1));
    set_step_count(4'd15);
    send_request(scan_req(16'h0002, 1'b1));
  endtask

  // Each phase reloads the table and then runs mostly scans
  task automatic test_random_sequences();
    for (int p = 0; p < 8; p++) begin
      set_step_count(STEP_PLAN[4*p +: 4]);
      for (int s = 0; s < N_RULES; s++) send_request(random_rule(3'(s)));
      for (int k = 0; k < 160; k++) send_request(random_item());
    end
  endtask

  // Hold the result side long enough for the input to back up
  task automatic test_output_stall();
    drain_results();
    sink_hold = 300;
    for (int k = 0; k < 100; k++) send_request(random_item());
    drain_results();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_streaming();
    idle_on = 1'b0;
    for (int k = 0; k < 200; k++) send_request(random_item());
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    sink_hold = 0;
    steps_cfg = ttss_pkg::STEP_RESET;
    coil_reg  = '0;
    out_reg   = '0;
    foreach (rule_tbl[i]) rule_tbl[i] = ttss_pkg::RULE_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_rule_matching();
    test_step_count();
    test_random_sequences();
    test_output_stall();
    test_streaming();

    drain_results();
    repeat (12) @(posedge clk);
    $display("run covered %0d scans and %0d rule writes, %0d results compared",
             n_scans, n_writes, n_checked);
    $display("step counts 0 to 15 incl. saturation, long output stall, drain pauses");
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
